FILE: rtl/glob_pattern_matcher_assert.svh
// Assertion macros used by the checker file of the glob pattern matcher.
// Every property is clocked on clk and disabled while arst_n is low.
`ifndef GLOB_PATTERN_MATCHER_ASSERT_SVH
`define GLOB_PATTERN_MATCHER_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define GPM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("glob matcher check failed");

// The consequent must hold in the same cycle as the antecedent.
`define GPM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("glob matcher check failed");

`endif

FILE: rtl/gpm_pkg.sv
// ----------------------------------------------------------------------------
// gpm_pkg
// Types, constants and helper functions of the glob pattern matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gpm_pkg;

	localparam int MaxPattern = 32;
	localparam int CharBits   = 8;
	localparam int WordBytes  = 8;
	localparam int NumWords   = MaxPattern / WordBytes;
	localparam int LenBits    = $clog2(MaxPattern + 1);
	localparam int CfgIdxBits = 3;
	localparam int CfgDataBits = 64;

	typedef logic [CharBits-1:0] char_t;
	typedef logic [MaxPattern:0] pos_set_t;
	typedef logic [MaxPattern-1:0] pos_mask_t;
	typedef logic [LenBits-1:0] len_t;

	localparam char_t ChStar  = char_t'(8'h2A);
	localparam char_t ChQuest = char_t'(8'h3F);
	localparam char_t ChOpen  = char_t'(8'h5B);
	localparam char_t ChClose = char_t'(8'h5D);
	localparam char_t ChDash  = char_t'(8'h2D);

	typedef enum logic [CfgIdxBits-1:0] {
		REG_PAT_0   = 3'd0,
		REG_PAT_1   = 3'd1,
		REG_PAT_2   = 3'd2,
		REG_PAT_3   = 3'd3,
		REG_PAT_LEN = 3'd4
	} cfg_reg_t;

	// Pattern decode that depends on configuration only.
	typedef struct packed {
		len_t                                n;
		pos_mask_t                           star;
		pos_mask_t                           quest;
		pos_mask_t                           plain;
		pos_mask_t                           open_c;
		pos_mask_t                           open_nc;
		logic [MaxPattern-1:0][CharBits-1:0] pat;
		logic [MaxPattern-1:0][CharBits-1:0] prv;
		logic [MaxPattern-1:0][CharBits-1:0] nxt;
		logic [MaxPattern-1:0][MaxPattern-1:0] lit;
		logic [MaxPattern-1:0][MaxPattern-1:0] rng;
		logic [MaxPattern-1:0][MaxPattern:0]   tgt;
		pos_set_t                            start;
	} gpm_dec_t;

	// Star closure as a parallel prefix: a live position reaches every later
	// position across an unbroken run of stars.
	function automatic pos_set_t star_closure(pos_set_t s, pos_mask_t star);
		pos_set_t g;
		pos_set_t p;
		pos_set_t gn;
		pos_set_t pn;
		g = s;
		p = '0;
		for (int q = 1; q <= MaxPattern; q++) begin
			p[q] = star[q-1];
		end
		for (int k = 1; k <= MaxPattern; k = k * 2) begin
			gn = g;
			pn = '0;
			for (int q = k; q <= MaxPattern; q++) begin
				gn[q] = g[q] | (p[q] & g[q-k]);
				pn[q] = p[q] & p[q-k];
			end
			g = gn;
			p = pn;
		end
		return g;
	endfunction

endpackage

FILE: rtl/gpm_decode.sv
// ----------------------------------------------------------------------------
// gpm_decode
// Classifies every pattern position and resolves the bracket groups, ranges
// and targets from the configured pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpm_decode (
	input  logic [gpm_pkg::NumWords-1:0][gpm_pkg::CfgDataBits-1:0] pat_words,
	input  logic [gpm_pkg::LenBits-1:0]                             pat_len,
	output gpm_pkg::gpm_dec_t                                       dec
);

	always_comb begin
		gpm_pkg::gpm_dec_t d;
		int n;
		int j;
		logic cons;
		logic is_rng;
		d = '0;
		n = (int'(pat_len) > gpm_pkg::MaxPattern) ? gpm_pkg::MaxPattern : int'(pat_len);
		d.n = gpm_pkg::len_t'(n);
		for (int q = 0; q < gpm_pkg::MaxPattern; q++) begin
			d.pat[q] = pat_words[q / gpm_pkg::WordBytes]
				[(q % gpm_pkg::WordBytes) * 8 +: gpm_pkg::CharBits];
		end
		for (int q = 0; q < gpm_pkg::MaxPattern; q++) begin
			d.prv[q] = (q > 0) ? d.pat[q-1] : '0;
			d.nxt[q] = (q < gpm_pkg::MaxPattern - 1) ? d.pat[q+1] : '0;
		end
		for (int i = 0; i < gpm_pkg::MaxPattern; i++) begin
			if (i < n) begin
				d.star[i]  = d.pat[i] == gpm_pkg::ChStar;
				d.quest[i] = d.pat[i] == gpm_pkg::ChQuest;
				d.plain[i] = !d.star[i] && !d.quest[i] && d.pat[i] != gpm_pkg::ChOpen;
			end
			// First closing bracket after this position.
			j = n;
			for (int q = gpm_pkg::MaxPattern - 1; q >= 0; q--) begin
				if (q > i && q < n && d.pat[q] == gpm_pkg::ChClose) begin
					j = q;
				end
			end
			if (i < n && d.pat[i] == gpm_pkg::ChOpen) begin
				d.open_c[i]  = j < n;
				d.open_nc[i] = j >= n;
			end
			if (j < n) begin
				d.tgt[i][j+1] = 1'b1;
			end
			// Walk the group: a range consumes the byte after the dash.
			cons = 1'b0;
			for (int q = 0; q < gpm_pkg::MaxPattern; q++) begin
				is_rng = 1'b0;
				if (q >= i && q < j) begin
					if (!cons && d.pat[q] == gpm_pkg::ChDash && q > i + 1 && q + 2 < n &&
						d.nxt[q] != gpm_pkg::ChClose && d.nxt[q] > d.prv[q]) begin
						is_rng = 1'b1;
					end
					d.rng[i][q] = is_rng;
					d.lit[i][q] = !cons && !is_rng;
				end
				cons = is_rng;
			end
		end
		d.start = gpm_pkg::star_closure(gpm_pkg::pos_set_t'(1), d.star);
		dec = d;
	end

endmodule

FILE: rtl/glob_pattern_matcher.sv
// ----------------------------------------------------------------------------
// glob_pattern_matcher
// Streams a string one byte per item against a configured glob pattern.
// ----------------------------------------------------------------------------
// Usage:
// The pattern is loaded through the cfg channel: indexes 0 to 3 take eight
// pattern bytes each (lowest byte first), index 4 takes the pattern length.
// cfg_ready is always high; write only while no string is in flight.
// Input items carry text_byte with first_byte, last_byte and empty_string
// flags. An item is taken at a clock edge with in_valid high and in_stall low.
// The set of live pattern positions updates in the cycle the item is taken,
// so one item per cycle is sustained while in_stall is low. An item flagged
// last_byte or empty_string produces one result, presented in the output
// register on the next cycle. The per-item path is a bit-parallel position
// update followed by a parallel-prefix star closure.
// While a result sits in the output register and out_stall is high, in_stall
// is raised and the result holds. Reset clears the pattern, the length, the
// live set and the output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glob_pattern_matcher (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [gpm_pkg::CfgIdxBits-1:0]     cfg_index,
	input  logic [gpm_pkg::CfgDataBits-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         text_byte,
	input  logic                               first_byte,
	input  logic                               last_byte,
	input  logic                               empty_string,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               matched
);

	logic [gpm_pkg::NumWords-1:0][gpm_pkg::CfgDataBits-1:0] pat_words_q;
	gpm_pkg::len_t      pat_len_q;
	gpm_pkg::pos_set_t  live_q;
	logic               out_valid_q;
	logic               matched_q;
	gpm_pkg::gpm_dec_t  dec;

	logic               in_acc;
	gpm_pkg::char_t     c;
	gpm_pkg::pos_mask_t eq;
	gpm_pkg::pos_mask_t rin;
	gpm_pkg::pos_mask_t hit;
	gpm_pkg::pos_set_t  cur;
	gpm_pkg::pos_set_t  step;
	gpm_pkg::pos_set_t  adv;
	gpm_pkg::pos_set_t  live_d;
	logic               res_d;
	logic               has_res;

	gpm_decode u_decode (
		.pat_words (pat_words_q),
		.pat_len   (pat_len_q),
		.dec       (dec)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q && out_stall;
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign matched   = matched_q;
	assign c         = text_byte[gpm_pkg::CharBits-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_words_q <= '0;
			pat_len_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gpm_pkg::REG_PAT_0:   pat_words_q[0] <= cfg_data;
				gpm_pkg::REG_PAT_1:   pat_words_q[1] <= cfg_data;
				gpm_pkg::REG_PAT_2:   pat_words_q[2] <= cfg_data;
				gpm_pkg::REG_PAT_3:   pat_words_q[3] <= cfg_data;
				gpm_pkg::REG_PAT_LEN: pat_len_q <= cfg_data[gpm_pkg::LenBits-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int q = 0; q < gpm_pkg::MaxPattern; q++) begin
			eq[q]  = dec.pat[q] == c;
			rin[q] = (dec.prv[q] < c) && (c <= dec.nxt[q]);
			hit[q] = |((dec.lit[q] & eq) | (dec.rng[q] & rin));
		end
	end

	always_comb begin
		cur  = first_byte ? dec.start : live_q;
		step = '0;
		for (int p = 0; p < gpm_pkg::MaxPattern; p++) begin
			if (cur[p]) begin
				if (dec.star[p]) begin
					step[p] = 1'b1;
				end
				if (dec.quest[p] || (dec.plain[p] && eq[p]) ||
					(dec.open_nc[p] && c == gpm_pkg::ChOpen)) begin
					step[p+1] = 1'b1;
				end
				if (dec.open_c[p] && hit[p]) begin
					step = step | dec.tgt[p];
				end
			end
		end
		adv = gpm_pkg::star_closure(step, dec.star);
		if (empty_string) begin
			live_d  = dec.start;
			has_res = 1'b1;
		end else begin
			live_d  = adv;
			has_res = last_byte;
		end
		res_d = live_d[dec.n];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				live_q <= live_d;
			end
			if (in_acc && has_res) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && has_res) begin
			matched_q <= res_d;
		end
	end

endmodule

FILE: rtl/gpm_checker.sv
// ----------------------------------------------------------------------------
// gpm_checker
// Port-level checks of the glob pattern matcher, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "glob_pattern_matcher_assert.svh"

module gpm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic first_byte,
	input logic last_byte,
	input logic empty_string,
	input logic out_valid,
	input logic out_stall,
	input logic matched
);

	logic res_acc;

	assign res_acc = in_valid && !in_stall && (last_byte || empty_string);

	`GPM_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid)
	`GPM_ASSERT_NEXT(a_hold_data, out_valid && out_stall, $stable(matched))
	// Every item that ends a string shows a result on the next cycle.
	`GPM_ASSERT_NEXT(a_result_follows, res_acc, out_valid)
	// A taken result is not repeated when nothing new arrived.
	`GPM_ASSERT_NEXT(a_no_repeat, out_valid && !out_stall && !res_acc, !out_valid)
	// The input side only stalls behind a waiting result.
	`GPM_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

endmodule

bind glob_pattern_matcher gpm_checker u_gpm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.first_byte   (first_byte),
	.last_byte    (last_byte),
	.empty_string (empty_string),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.matched      (matched)
);

FILE: test/tb_glob_pattern_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glob_pattern_matcher
// Self-checking bench for the streaming glob matcher. A short table of
// directed items runs first. Random patterns and strings follow, with random
// gaps on the input side and random stalls on the output side. Each result is
// compared with a fixed value from the table or with a bit-level model of the live position set kept here.
// ----------------------------------------------------------------------------

module tb_glob_pattern_matcher;

	localparam int NumRandomItems = 1250;
	localparam int IdleLimit      = 5000;

	typedef struct {
		logic [7:0] txt;
		logic       first;
		logic       last;
		logic       empty;
		int         want;   // -1: take the value from the model below
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  text_byte;
	logic        first_byte;
	logic        last_byte;
	logic        empty_string;
	logic        out_valid;
	logic        out_stall;
	logic        matched;

	// Shadow copy of the configuration and of the live position set.
	logic [7:0]  pat_mem [gpm_pkg::MaxPattern];
	logic [5:0]  len_reg;
	logic [32:0] live_set;

	logic        match_queue [$];
	int          errors;
	int          idle_cycles;
	int          stall_level;

	glob_pattern_matcher u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.text_byte    (text_byte),
		.first_byte   (first_byte),
		.last_byte    (last_byte),
		.empty_string (empty_string),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.matched      (matched)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int active_len();
		return (len_reg > gpm_pkg::MaxPattern) ? gpm_pkg::MaxPattern : int'(len_reg);
	endfunction

	function automatic logic [7:0] pat_byte(int i);
		return (i >= gpm_pkg::MaxPattern) ? 8'h00 : pat_mem[i];
	endfunction

	// First closing bracket after position i, or n when there is none.
	function automatic int bracket_end(int i, int n);
		for (int p = i + 1; p < n; p++) begin
			if (pat_byte(p) == gpm_pkg::ChClose) return p;
		end
		return n;
	endfunction

	function automatic bit group_holds(int i, int j, int n, logic [7:0] c);
		int p;
		p = i;
		while (p < j) begin
			if (pat_byte(p) == gpm_pkg::ChDash && p > i + 1 && p + 2 < n &&
					pat_byte(p + 1) != gpm_pkg::ChClose &&
					pat_byte(p + 1) > pat_byte(p - 1)) begin
				if (pat_byte(p - 1) < c && c <= pat_byte(p + 1)) return 1'b1;
				p++;
			end else if (pat_byte(p) == c) begin
				return 1'b1;
			end
			p++;
		end
		return 1'b0;
	endfunction

	function automatic logic [32:0] star_fill(logic [32:0] s, int n);
		for (int p = 0; p < n; p++) begin
			if (s[p] && pat_byte(p) == gpm_pkg::ChStar) s[p + 1] = 1'b1;
		end
		return s;
	endfunction

	function automatic logic [32:0] next_set(logic [32:0] s, int n, logic [7:0] c);
		logic [32:0] t;
		int j;
		t = '0;
		for (int p = 0; p < n; p++) begin
			if (s[p]) begin
				if (pat_byte(p) == gpm_pkg::ChStar) begin
					t[p] = 1'b1;
				end else if (pat_byte(p) == gpm_pkg::ChQuest) begin
					t[p + 1] = 1'b1;
				end else if (pat_byte(p) == gpm_pkg::ChOpen) begin
					j = bracket_end(p, n);
					if (j < n) begin
						if (group_holds(p, j, n, c)) t[j + 1] = 1'b1;
					end else if (c == gpm_pkg::ChOpen) begin
						t[p + 1] = 1'b1;
					end
				end else if (pat_byte(p) == c) begin
					t[p + 1] = 1'b1;
				end
			end
		end
		return star_fill(t, n);
	endfunction

	// Updates the live set for one accepted item; returns 1 when a result is due.
	function automatic bit match_step(logic [7:0] c, logic f, logic l, logic e,
			output logic hit);
		int n;
		n = active_len();
		hit = 1'b0;
		if (e) begin
			live_set = star_fill(33'd1, n);
			hit = live_set[n];
			return 1'b1;
		end
		if (f) live_set = star_fill(33'd1, n);
		live_set = next_set(live_set, n, c);
		hit = live_set[n];
		return l;
	endfunction

	task automatic cfg_write(gpm_pkg::cfg_reg_t idx, logic [63:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == gpm_pkg::REG_PAT_LEN) begin
			len_reg = value[5:0];
		end else begin
			for (int b = 0; b < 8; b++) pat_mem[int'(idx) * 8 + b] = value[b*8 +: 8];
		end
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data  = '0;
	endtask

	task automatic wait_drained();
		while (match_queue.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic load_pattern(logic [7:0] bytes [gpm_pkg::MaxPattern], logic [5:0] len);
		logic [63:0] word;
		wait_drained();
		for (int w = 0; w < gpm_pkg::NumWords; w++) begin
			for (int b = 0; b < 8; b++) word[b*8 +: 8] = bytes[w*8 + b];
			cfg_write(gpm_pkg::cfg_reg_t'(int'(gpm_pkg::REG_PAT_0) + w), word);
		end
		cfg_write(gpm_pkg::REG_PAT_LEN, 64'(len));
	endtask

	// Drives one item from the falling edge and holds it until it is taken.
	task automatic send_item(logic [7:0] c, logic f, logic l, logic e, int want);
		logic hit;
		@(negedge clk);
		in_valid     = 1'b1;
		text_byte    = c;
		first_byte   = f;
		last_byte    = l;
		empty_string = e;
		do @(posedge clk); while (in_stall);
		if (match_step(c, f, l, e, hit)) begin
			match_queue.push_back((want < 0) ? hit : logic'(want));
		end
	endtask

	task automatic sender_gap(inout int burst_left);
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 12);
		gap = $urandom_range(0, 6);
		if (gap != 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	function automatic logic [7:0] pick_pattern_char();
		case ($urandom_range(0, 11))
			0, 1: return gpm_pkg::ChStar;
			2:    return gpm_pkg::ChQuest;
			3:    return gpm_pkg::ChOpen;
			4:    return gpm_pkg::ChClose;
			5:    return gpm_pkg::ChDash;
			6:    return 8'($urandom);
			default: return 8'h61 + 8'($urandom_range(0, 4));
		endcase
	endfunction

	function automatic logic [7:0] pick_text_char(int n);
		case ($urandom_range(0, 5))
			0:    return 8'($urandom);
			1, 2: return (n > 0) ? pat_byte($urandom_range(0, n - 1)) : 8'h61;
			default: return 8'h61 + 8'($urandom_range(0, 4));
		endcase
	endfunction

	// Receiver: stall level changes from phase to phase, sometimes zero.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_level);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (match_queue.size() == 0) begin
				$display("%0t: unexpected result matched=%0b", $realtime, matched);
				errors++;
			end else begin
				if (matched !== match_queue[0]) begin
					$display("%0t: matched mismatch: expected %0b, actual %0b",
						$realtime, match_queue[0], matched);
					errors++;
				end
				void'(match_queue.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		dir_row_t    at_reset [3];
		dir_row_t    directed [18];
		logic [7:0]  bytes [gpm_pkg::MaxPattern];
		logic [7:0]  dir_pat [9];
		int          sent;
		int          burst_left;
		int          plen;
		int          slen;
		logic [5:0]  len_wr;

		at_reset = '{
			'{8'h61, 1'b0, 1'b1, 1'b0, 0},   // continuation with an empty set
			'{8'hFF, 1'b0, 1'b0, 1'b1, 1},   // empty string, empty pattern
			'{8'h00, 1'b1, 1'b1, 1'b0, 0}    // one byte, empty pattern
		};
		// Pattern a[b-d]?*[ : a range group, any byte, a star and an unclosed bracket.
		dir_pat = '{8'h61, gpm_pkg::ChOpen, 8'h62, gpm_pkg::ChDash, 8'h64,
			gpm_pkg::ChClose, gpm_pkg::ChQuest, gpm_pkg::ChStar, gpm_pkg::ChOpen};
		directed = '{
			'{8'h61, 1'b1, 1'b0, 1'b0, -1}, '{8'h63, 1'b0, 1'b0, 1'b0, -1},
			'{8'hFF, 1'b0, 1'b0, 1'b0, -1}, '{gpm_pkg::ChOpen, 1'b0, 1'b1, 1'b0, -1},
			'{8'h61, 1'b1, 1'b0, 1'b0, -1}, '{8'h62, 1'b0, 1'b0, 1'b0, -1},
			'{8'h00, 1'b0, 1'b0, 1'b0, -1}, '{8'h7A, 1'b0, 1'b0, 1'b0, -1},
			'{gpm_pkg::ChOpen, 1'b0, 1'b1, 1'b0, -1}, '{8'h61, 1'b1, 1'b0, 1'b0, -1},
			'{8'h64, 1'b0, 1'b0, 1'b0, -1}, '{8'h41, 1'b0, 1'b0, 1'b0, -1},
			'{gpm_pkg::ChOpen, 1'b0, 1'b1, 1'b0, -1}, '{8'h61, 1'b1, 1'b0, 1'b0, -1},
			'{gpm_pkg::ChOpen, 1'b0, 1'b0, 1'b0, -1}, '{8'h00, 1'b0, 1'b1, 1'b0, -1},
			'{8'h00, 1'b0, 1'b0, 1'b1, 0},   // empty string against a non-empty literal start
			'{8'h62, 1'b1, 1'b1, 1'b0, 0}
		};

		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = gpm_pkg::REG_PAT_0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		text_byte    = '0;
		first_byte   = 1'b0;
		last_byte    = 1'b0;
		empty_string = 1'b0;
		errors       = 0;
		stall_level  = 30;
		len_reg      = '0;
		live_set     = '0;
		for (int i = 0; i < gpm_pkg::MaxPattern; i++) pat_mem[i] = 8'h00;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (at_reset[i]) begin
			send_item(at_reset[i].txt, at_reset[i].first, at_reset[i].last,
				at_reset[i].empty, at_reset[i].want);
		end
		foreach (bytes[i]) bytes[i] = (i < 9) ? dir_pat[i] : 8'h00;
		@(negedge clk);
		in_valid = 1'b0;
		load_pattern(bytes, 6'd9);
		foreach (directed[i]) begin
			send_item(directed[i].txt, directed[i].first, directed[i].last,
				directed[i].empty, directed[i].want);
		end

		// Length above the maximum is clipped; the star pattern then accepts anything.
		foreach (bytes[i]) bytes[i] = gpm_pkg::ChStar;
		@(negedge clk);
		in_valid = 1'b0;
		load_pattern(bytes, 6'd63);
		send_item(8'hFF, 1'b1, 1'b1, 1'b0, 1);
		send_item(8'h00, 1'b0, 1'b0, 1'b1, 1);

		sent = 0;
		burst_left = 0;
		while (sent < NumRandomItems) begin
			@(negedge clk);
			in_valid = 1'b0;
			plen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, gpm_pkg::MaxPattern)
				: $urandom_range(1, 8);
			foreach (bytes[i]) begin
				bytes[i] = (i < plen) ? pick_pattern_char() : 8'($urandom);
			end
			case ($urandom_range(0, 9))
				0:       len_wr = 6'($urandom_range(gpm_pkg::MaxPattern + 1, 63));
				1:       len_wr = 6'd0;
				default: len_wr = 6'(plen);
			endcase
			load_pattern(bytes, len_wr);
			stall_level = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 80);
			for (int s = 0; s < 12 && sent < NumRandomItems; s++) begin
				if ($urandom_range(0, 9) == 0) begin
					// Noise: any mix of flags, including continuation and empty strings.
					sender_gap(burst_left);
					send_item(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), -1);
					sent++;
				end else begin
					slen = $urandom_range(0, 9);
					if (slen == 0) begin
						sender_gap(burst_left);
						send_item(8'($urandom), 1'($urandom), 1'($urandom), 1'b1, -1);
						sent++;
					end
					for (int k = 0; k < slen; k++) begin
						sender_gap(burst_left);
						send_item(pick_text_char(active_len()), k == 0, k == slen - 1, 1'b0, -1);
						sent++;
					end
				end
				if (s == 6 && sent < 200) begin
					@(negedge clk);
					in_valid = 1'b0;
					while (match_queue.size() != 0) @(posedge clk);
				end
			end
		end
		@(negedge clk);
		in_valid = 1'b0;
		while (match_queue.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
